FILE: rtl/owbm_pkg.sv
package owbm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_BIT_LOW,
        PH_BIT_REL,
        PH_RD_SAMPLE,
        PH_RD_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_COUNT = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL    = 3'd5;

    localparam logic [7:0] CFG_RESET_VAL [CFG_COUNT] = '{
        8'd88, 8'd10, 8'd78, 8'd10, 8'd1, 8'd7
    };

    localparam logic [2:0] BIT_LAST = 3'd7;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic       start;
        t_op        op;
        logic [7:0] data_byte;
        logic       line_level;
    } t_cmd_word;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } t_res_word;

    // phase length minus one, zero counting as one
    function automatic logic [7:0] f_count(input logic [7:0] v);
        f_count = (v == 8'd0) ? 8'd0 : v - 8'd1;
    endfunction

endpackage

FILE: rtl/owbm_if.sv
interface owbm_in_if import owbm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output mode, output data_byte, output line_level,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input line_level,
                    output ready);
endinterface

interface owbm_out_if import owbm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_data, output ready);
endinterface

interface owbm_cfg_if import owbm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/owbm_front.sv
module owbm_front import owbm_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    owbm_in_if.sink       i_in,
    output logic          o_q_valid,
    output t_cmd_word     o_q_word,
    input  logic          i_q_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd_word       r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    t_cmd_word       w_word;
    logic            w_push;

    assign i_in.ready = (r_count != CW'(QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_word   = r_mem[r_rd];

    always_comb begin
        w_word.start      = (t_op'(i_in.mode) != OP_TICK);
        w_word.op         = t_op'(i_in.mode);
        w_word.data_byte  = i_in.data_byte;
        w_word.line_level = i_in.line_level;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_q_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/owbm_back.sv
module owbm_back import owbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd_word i_q_word,
    output logic      o_q_pop,
    owbm_cfg_if.sink  i_cfg,
    owbm_out_if.source o_out
);

    logic [7:0] r_cfg [CFG_COUNT];
    t_phase     r_phase, n_phase;
    logic [7:0] r_tick, n_tick;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_pres, n_pres;
    t_op        r_op, n_op;
    logic [7:0] r_latch, n_latch;
    logic       r_out_valid;
    t_res_word  r_res, n_res;

    assign i_cfg.ready = 1'b1;
    assign o_q_pop     = i_q_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        t_phase v_ph;
        logic   v_end;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pres  = r_pres;
        n_op    = r_op;
        n_latch = r_latch;
        n_res   = '0;
        v_end   = 1'b0;

        if (r_phase == PH_IDLE && i_q_word.start) begin
            n_op  = i_q_word.op;
            n_bit = '0;
            if (i_q_word.op == OP_RESET) begin
                n_phase = PH_RST_LOW;
                n_tick  = f_count(r_cfg[CFG_RESET_LOW]);
            end else begin
                n_shift = (i_q_word.op == OP_WRITE) ? i_q_word.data_byte : 8'd0;
                n_phase = PH_BIT_LOW;
                n_tick  = (i_q_word.op == OP_WRITE && !n_shift[0])
                        ? f_count(r_cfg[CFG_WRITE_SLOT]) : f_count(r_cfg[CFG_SHORT_LOW]);
            end
        end

        v_ph = n_phase;
        if (v_ph != PH_IDLE) begin
            n_res.busy_res  = 1'b1;
            n_res.drive_low = (v_ph == PH_RST_LOW) || (v_ph == PH_BIT_LOW);
            if (v_ph == PH_RD_SAMPLE) begin
                n_shift = {i_q_word.line_level, n_shift[7:1]};
            end
            if (v_ph == PH_RST_WAIT && n_tick == 8'd0) begin
                n_pres = !i_q_word.line_level;
            end

            if (n_tick != 8'd0) begin
                n_tick = n_tick - 8'd1;
            end else begin
                unique case (v_ph)
                    PH_RST_LOW: begin
                        n_phase = PH_RST_WAIT;
                        n_tick  = f_count(r_cfg[CFG_PRESENCE_WAIT]);
                    end
                    PH_RST_WAIT: begin
                        if (r_cfg[CFG_RESET_TAIL] == 8'd0) begin
                            n_phase        = PH_IDLE;
                            n_op           = OP_TICK;
                            n_bit          = '0;
                            n_tick         = '0;
                            n_res.done_res = 1'b1;
                        end else begin
                            n_phase = PH_RST_TAIL;
                            n_tick  = f_count(r_cfg[CFG_RESET_TAIL]);
                        end
                    end
                    PH_BIT_LOW: begin
                        if (n_op == OP_WRITE) begin
                            n_phase = PH_BIT_REL;
                            n_tick  = n_shift[0] ? f_count(r_cfg[CFG_WRITE_SLOT]) : 8'd0;
                        end else begin
                            n_phase = PH_RD_SAMPLE;
                            n_tick  = 8'd0;
                        end
                    end
                    PH_BIT_REL: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        v_end   = 1'b1;
                    end
                    PH_RD_SAMPLE: begin
                        if (r_cfg[CFG_READ_TAIL] == 8'd0) begin
                            v_end = 1'b1;
                        end else begin
                            n_phase = PH_RD_TAIL;
                            n_tick  = f_count(r_cfg[CFG_READ_TAIL]);
                        end
                    end
                    PH_RD_TAIL: begin
                        v_end = 1'b1;
                    end
                    default: begin
                        n_phase        = PH_IDLE;
                        n_op           = OP_TICK;
                        n_bit          = '0;
                        n_tick         = '0;
                        n_res.done_res = 1'b1;
                    end
                endcase
            end

            if (v_end) begin
                if (n_bit == BIT_LAST) begin
                    if (n_op == OP_READ) begin
                        n_latch = n_shift;
                    end
                    n_phase        = PH_IDLE;
                    n_op           = OP_TICK;
                    n_bit          = '0;
                    n_tick         = '0;
                    n_res.done_res = 1'b1;
                end else begin
                    n_bit   = n_bit + 3'd1;
                    n_phase = PH_BIT_LOW;
                    n_tick  = (n_op == OP_WRITE && !n_shift[0])
                            ? f_count(r_cfg[CFG_WRITE_SLOT]) : f_count(r_cfg[CFG_SHORT_LOW]);
                end
            end
        end

        n_res.presence  = n_pres;
        n_res.read_data = n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET_VAL[i];
            end
        end else if (i_cfg.valid && i_cfg.index < CFG_IDX_W'(CFG_COUNT)) begin
            r_cfg[i_cfg.index] <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_pres      <= 1'b0;
            r_op        <= OP_TICK;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_pres      <= n_pres;
                r_op        <= n_op;
                r_latch     <= n_latch;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_res.drive_low;
    assign o_out.busy_res  = r_res.busy_res;
    assign o_out.done_res  = r_res.done_res;
    assign o_out.presence  = r_res.presence;
    assign o_out.read_data = r_res.read_data;

endmodule

FILE: rtl/one_wire_bus_master_unit.sv
// One-wire bus master timing engine. Each input word is one timing tick that may also
// start a reset, a write byte or a read byte while the engine is idle; every word gives
// exactly one result word with the line drive, busy, done, presence and last read byte.
// One word is taken every clock when the output side keeps up. A word is written into
// the input queue and is then stepped from it into the output register, which offers
// its result word until it is taken. The queue (QUEUE_DEPTH words) absorbs output
// stalls. Timing registers are to be written through the configuration channel only
// while the engine is idle; the block itself does not enforce this.
module one_wire_bus_master_unit import owbm_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    owbm_in_if.sink    i_in,
    owbm_out_if.source o_out,
    owbm_cfg_if.sink   i_cfg
);

    logic      w_q_valid;
    t_cmd_word w_q_word;
    logic      w_q_pop;

    owbm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_word  (w_q_word),
        .i_q_pop   (w_q_pop)
    );

    owbm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_word  (w_q_word),
        .o_q_pop   (w_q_pop),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule
